@@ hw/rtl/bba_pkg.sv @@
// Types and constants of the buddy block allocator.
package bba_pkg;
    localparam int unsigned C_MAX_LOG2 = 10;
    localparam int unsigned C_NW = C_MAX_LOG2 + 1;
    localparam int unsigned C_NODES = 1 << C_NW;

    typedef enum logic [1:0] {
        NODE_ABSENT   = 2'd0,
        NODE_FREE     = 2'd1,
        NODE_SPLIT    = 2'd2,
        NODE_OCCUPIED = 2'd3
    } t_node;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_NOT_OCC  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_RD, S_A_EV, S_A_UP, S_SP1, S_SP2, S_OCC,
        S_F_EV, S_M_RD, S_M_EV, S_M_W2, S_M_W3, S_FIN
    } t_state;
endpackage

@@ hw/rtl/bba_if.sv @@
// Request and result channel interfaces of the buddy block allocator.
interface bba_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [10:0] request_size;
    logic [10:0] node_index;
    modport source (output valid, action, request_size, node_index, input ready);
    modport sink (input valid, action, request_size, node_index, output ready);
endinterface

interface bba_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [10:0] granted_node;
    logic [9:0]  block_offset;
    logic [3:0]  block_size_log2;
    logic [10:0] free_units;
    modport source (output valid, status, granted_node, block_offset, block_size_log2,
        free_units, input ready);
    modport sink (input valid, status, granted_node, block_offset, block_size_log2,
        free_units, output ready);
endinterface

@@ hw/rtl/buddy_block_allocator_unit.sv @@
// Buddy block allocator: node tree in one synchronous memory, walked by a sequencer.
// One item at a time; each tree access is a registered read of the node memory. Query
// goes straight to the result. Allocate walks the tree depth first (descend into split
// nodes, step to siblings, climb levels), splits the found node level by level, marks it
// occupied and returns. Free checks that the node is occupied, merges it with its free
// buddy level by level until the buddy is not free, and returns. Init, and reset, sweep all
// 2048 tree entries, one per cycle, before the next beat is taken.
module buddy_block_allocator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    bba_in_if.sink     i_in,
    bba_out_if.source  o_out
);
    import bba_pkg::*;

    localparam logic [3:0] C_MAXL = 4'(C_MAX_LOG2);

    logic [1:0] mem [C_NODES];
    logic [1:0] r_rd_data;
    logic [C_NW-1:0] rd_addr, w_addr;
    logic [1:0] w_data;
    logic w_en;

    t_state r_state, n_state;
    logic [C_NW-1:0] r_cnt, n_cnt, r_n, n_n;
    logic [3:0] r_cfg, r_t, n_t, r_d, n_d, r_sz, n_sz;
    logic [10:0] r_free, n_free, r_req, n_req, r_gn, n_gn;
    logic [9:0] r_off, n_off;
    logic [1:0] r_st, n_st;
    logic r_init, n_init;
    logic r_ov, n_ov;
    logic [1:0] r_o_st, n_o_st;
    logic [10:0] r_o_gn, n_o_gn, r_o_fr, n_o_fr;
    logic [9:0] r_o_off, n_o_off;
    logic [3:0] r_o_sz, n_o_sz;
    logic [10:0] size_cur, size_half;
    logic [11:0] idx_lim;
    logic [3:0] idx_depth;

    function automatic logic [3:0] msb_pos(input logic [10:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 11; i++) begin
            if (v[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign size_cur  = 11'(1) << (r_t - r_d);
    assign size_half = 11'(1) << (r_t - r_d - 4'd1);
    assign idx_lim   = 12'd2 << r_t;
    assign idx_depth = msb_pos(i_in.node_index);

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.status = r_o_st;
    assign o_out.granted_node = r_o_gn;
    assign o_out.block_offset = r_o_off;
    assign o_out.block_size_log2 = r_o_sz;
    assign o_out.free_units = r_o_fr;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_n = r_n; n_t = r_t; n_d = r_d;
        n_sz = r_sz; n_free = r_free; n_req = r_req; n_gn = r_gn; n_off = r_off;
        n_st = r_st; n_init = r_init;
        n_ov = r_ov & ~o_out.ready;
        n_o_st = r_o_st; n_o_gn = r_o_gn; n_o_off = r_o_off; n_o_sz = r_o_sz;
        n_o_fr = r_o_fr;
        rd_addr = r_n; w_en = 1'b0; w_addr = r_n; w_data = NODE_ABSENT;
        unique case (r_state)
            S_CLEAR: begin
                w_en = 1'b1;
                w_addr = r_cnt;
                w_data = (r_cnt == C_NW'(1)) ? NODE_FREE : NODE_ABSENT;
                n_cnt = r_cnt + C_NW'(1);
                if (&r_cnt) begin
                    n_state = r_init ? S_FIN : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_st = ST_OK; n_gn = '0; n_off = '0; n_sz = '0;
                    n_req = i_in.request_size;
                    n_n = C_NW'(1); n_d = '0;
                    unique case (t_action'(i_in.action))
                        ACT_INIT: begin
                            n_t = (r_cfg > C_MAXL) ? C_MAXL : r_cfg;
                            n_free = 11'(1) << n_t;
                            n_cnt = '0; n_init = 1'b1;
                            n_state = S_CLEAR;
                        end
                        ACT_ALLOC: begin
                            if (i_in.request_size == '0 ||
                                i_in.request_size > (11'(1) << r_t)) begin
                                n_st = ST_BAD_SIZE;
                                n_state = S_FIN;
                            end else begin
                                rd_addr = C_NW'(1);
                                n_state = S_A_EV;
                            end
                        end
                        ACT_FREE: begin
                            if (i_in.node_index == '0 || {1'b0, i_in.node_index} >= idx_lim) begin
                                n_st = ST_NOT_OCC;
                                n_state = S_FIN;
                            end else begin
                                rd_addr = C_NW'(i_in.node_index);
                                n_n = C_NW'(i_in.node_index);
                                n_d = idx_depth;
                                n_state = S_F_EV;
                            end
                        end
                        ACT_QUERY: n_state = S_FIN;
                    endcase
                end
            end
            S_A_RD: begin
                n_state = S_A_EV;
            end
            S_A_EV: begin
                if (size_cur >= r_req && r_rd_data == NODE_FREE) begin
                    n_state = S_SP1;
                end else if (size_cur >= r_req && r_rd_data == NODE_SPLIT && r_d < r_t) begin
                    n_n = r_n << 1; n_d = r_d + 4'd1;
                    n_state = S_A_RD;
                end else begin
                    n_state = S_A_UP;
                end
            end
            S_A_UP: begin
                if (r_n[0] && r_n != C_NW'(1)) begin
                    n_n = r_n >> 1; n_d = r_d - 4'd1;
                end else if (r_n == C_NW'(1)) begin
                    n_st = ST_NO_SPACE;
                    n_state = S_FIN;
                end else begin
                    n_n = r_n + C_NW'(1);
                    n_state = S_A_RD;
                end
            end
            S_SP1: begin
                if (r_d < r_t && r_req <= size_half) begin
                    w_en = 1'b1; w_data = NODE_SPLIT;
                    n_state = S_SP2;
                end else begin
                    n_state = S_OCC;
                end
            end
            S_SP2: begin
                w_en = 1'b1; w_addr = {r_n[C_NW-2:0], 1'b1}; w_data = NODE_FREE;
                n_n = r_n << 1; n_d = r_d + 4'd1;
                n_state = S_SP1;
            end
            S_OCC: begin
                w_en = 1'b1; w_data = NODE_OCCUPIED;
                n_sz = r_t - r_d;
                n_free = r_free - size_cur;
                n_gn = 11'(r_n);
                n_off = 10'((11'(r_n) - (11'(1) << r_d)) << (r_t - r_d));
                n_state = S_FIN;
            end
            S_F_EV: begin
                if (r_rd_data != NODE_OCCUPIED) begin
                    n_st = ST_NOT_OCC;
                    n_state = S_FIN;
                end else begin
                    w_en = 1'b1; w_data = NODE_FREE;
                    n_free = r_free + size_cur;
                    n_state = S_M_RD;
                end
            end
            S_M_RD: begin
                rd_addr = r_n ^ C_NW'(1);
                n_state = (r_n == C_NW'(1)) ? S_FIN : S_M_EV;
            end
            S_M_EV: begin
                if (r_rd_data == NODE_FREE) begin
                    w_en = 1'b1; w_addr = r_n ^ C_NW'(1); w_data = NODE_ABSENT;
                    n_state = S_M_W2;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_M_W2: begin
                w_en = 1'b1; w_data = NODE_ABSENT;
                n_state = S_M_W3;
            end
            S_M_W3: begin
                w_en = 1'b1; w_addr = r_n >> 1; w_data = NODE_FREE;
                n_n = r_n >> 1;
                n_state = S_M_RD;
            end
            S_FIN: begin
                if (!r_ov || o_out.ready) begin
                    n_ov = 1'b1;
                    n_o_st = r_st; n_o_gn = r_gn; n_o_off = r_off; n_o_sz = r_sz;
                    n_o_fr = r_free;
                    n_init = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_cfg <= C_MAXL;
            r_t <= C_MAXL;
            r_free <= 11'(1) << C_MAXL;
            r_init <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_t <= n_t;
            r_free <= n_free;
            r_init <= n_init;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n; r_d <= n_d; r_sz <= n_sz; r_req <= n_req; r_gn <= n_gn;
        r_off <= n_off; r_st <= n_st;
        r_o_st <= n_o_st; r_o_gn <= n_o_gn; r_o_off <= n_o_off; r_o_sz <= n_o_sz;
        r_o_fr <= n_o_fr;
    end
endmodule

@@ hw/rtl/bba_checker.sv @@
// Port checker of the buddy block allocator and its bind.
module bba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [10:0] i_granted_node,
    input logic [9:0]  i_block_offset,
    input logic [3:0]  i_block_size_log2,
    input logic [10:0] i_free_units
);
    import bba_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_granted_node == '0)
        else $error("grant on failed item");
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_free_units <= 11'd1024)
        else $error("free units out of range");
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((11'(i_block_offset) & ((11'(1) << i_block_size_log2) - 11'd1))
        == '0))
        else $error("block offset not aligned");
endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_status(o_out.status),
    .i_granted_node(o_out.granted_node),
    .i_block_offset(o_out.block_offset),
    .i_block_size_log2(o_out.block_size_log2),
    .i_free_units(o_out.free_units)
);
